[src/bls_pkg.sv]
// bls_pkg: shared types and constants of the bresenham line stepper
// holds configuration register codes, reset values and the config struct
// no dependencies

package bls_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // configuration register widths
    localparam int VIEW_W = 15;
    localparam int FW_W   = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;

    // configuration reset values
    localparam logic [VIEW_W-1:0] VIEW_X_RESET = 15'd1920;
    localparam logic [VIEW_W-1:0] VIEW_Y_RESET = 15'd1080;
    localparam logic [FW_W-1:0]   FW_RESET     = 14'd1920;

    // request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // live configuration handed to the datapath
    typedef struct packed {
        logic [VIEW_W-1:0] view_x_limit;
        logic [VIEW_W-1:0] view_y_limit;
        logic [FW_W-1:0]   frame_width;
    } t_cfg;

endpackage

[src/bresenham_line_stepper.sv]
// bresenham_line_stepper: top level of the integer line rasterizer
// depends on bls_pkg, bls_cfg_regs, bls_stepper and bls_addr_unit
//
// usage:
// - input channel (i_in_valid / o_in_ready): a load request latches start,
//   end and major axis; a step request emits the current pixel and advances
// - every request gives exactly one result on the output channel
//   (o_out_valid / i_out_ready); load requests and steps past the end of a
//   line return a result with o_pixel_valid low and all fields zero
// - config channel (i_cfg_valid / o_cfg_ready): index 0 view x limit,
//   1 view y limit, 2 frame width; other indexes are ignored; write only
//   while no request is in flight
// - pipeline: two register stages; a request is registered in the first
//   stage, then its result in the output register, where it is held until taken
// - throughput: one request per cycle while the output drains; the line state
//   update (one add and sign test on the error term) completes in the accept
//   cycle, the address multiply-add sits in the second stage
// - reset: view 1920 x 1080, frame width 1920, no line active
// - receiver stall: the output register holds, the first stage still takes
//   one more request, then o_in_ready drops until the output drains

module bresenham_line_stepper #(
    parameter int COORD_BITS = 16,
    parameter int ADDR_BITS  = 26
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic                            i_y_major,
    input  logic signed [COORD_BITS-1:0]    i_start_x,
    input  logic signed [COORD_BITS-1:0]    i_start_y,
    input  logic signed [COORD_BITS-1:0]    i_end_x,
    input  logic signed [COORD_BITS-1:0]    i_end_y,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_pixel_valid,
    output logic signed [COORD_BITS-1:0]    o_pixel_x,
    output logic signed [COORD_BITS-1:0]    o_pixel_y,
    output logic                            o_in_view,
    output logic [ADDR_BITS-1:0]            o_pixel_address,
    output logic                            o_last_pixel
);
    import bls_pkg::*;

    t_cfg w_cfg;

    logic                       w_s2_ready;
    logic                       w_s1_valid;
    logic                       w_s1_pixel_valid;
    logic signed [COORD_BITS:0] w_s1_x;
    logic signed [COORD_BITS:0] w_s1_y;
    logic                       w_s1_last;

    // configuration registers
    bls_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // line state and first stage
    bls_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_y_major        (i_y_major),
        .i_start_x        (i_start_x),
        .i_start_y        (i_start_y),
        .i_end_x          (i_end_x),
        .i_end_y          (i_end_y),
        .i_s2_ready       (w_s2_ready),
        .o_s1_valid       (w_s1_valid),
        .o_s1_pixel_valid (w_s1_pixel_valid),
        .o_s1_x           (w_s1_x),
        .o_s1_y           (w_s1_y),
        .o_s1_last        (w_s1_last)
    );

    // view test, address and output register
    bls_addr_unit #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_addr_unit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_s1_valid      (w_s1_valid),
        .o_s2_ready      (w_s2_ready),
        .i_pixel_valid   (w_s1_pixel_valid),
        .i_x             (w_s1_x),
        .i_y             (w_s1_y),
        .i_last          (w_s1_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_in_view       (o_in_view),
        .o_pixel_address (o_pixel_address),
        .o_last_pixel    (o_last_pixel)
    );

    // the pipeline never holds more than two requests: a full output with a
    // stall must stop intake once the first stage is occupied
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_valid && o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken with both stages full");

endmodule

[src/bls_cfg_regs.sv]
// bls_cfg_regs: view limit and frame width registers behind the config port
// depends on bls_pkg

module bls_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bls_pkg::t_cfg                   o_cfg
);
    import bls_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VIEW_X_LIMIT: n_cfg.view_x_limit = i_cfg_data[VIEW_W-1:0];
                REG_VIEW_Y_LIMIT: n_cfg.view_y_limit = i_cfg_data[VIEW_W-1:0];
                REG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg_data[FW_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_x_limit <= VIEW_X_RESET;
            r_cfg.view_y_limit <= VIEW_Y_RESET;
            r_cfg.frame_width  <= FW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[src/bls_stepper.sv]
// bls_stepper: line state, error term update and first pipeline register
// depends on bls_pkg

module bls_stepper #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic                         i_y_major,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_s2_ready,
    output logic                         o_s1_valid,
    output logic                         o_s1_pixel_valid,
    output logic signed [COORD_BITS:0]   o_s1_x,
    output logic signed [COORD_BITS:0]   o_s1_y,
    output logic                         o_s1_last
);
    import bls_pkg::*;

    localparam int W = COORD_BITS + 1;
    localparam int E = COORD_BITS + 4;

    // line state
    logic signed [W-1:0]          r_cur_x, n_cur_x;
    logic signed [W-1:0]          r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_target, n_target;
    logic signed [W-1:0]          r_dmin, n_dmin;
    logic signed [W-1:0]          r_dmaj, n_dmaj;
    logic [E-1:0]                 r_err, n_err;
    logic                         r_mode, n_mode;
    logic                         r_done, n_done;

    // stage 1 register
    logic                r_s1_valid;
    logic                r_pv;
    logic signed [W-1:0] r_px;
    logic signed [W-1:0] r_py;
    logic                r_last;

    logic w_en;
    logic w_fire;
    logic w_emit;

    // step datapath
    logic signed [W-1:0] w_major;
    logic signed [W-1:0] w_minor;
    logic signed [W-1:0] w_minor_step;
    logic signed [W-1:0] w_major_next;
    logic [W-1:0]        w_adm;
    logic [E-1:0]        w_adm_e;
    logic [E-1:0]        w_dmaj_e;
    logic                w_err_pos;
    logic [E-1:0]        w_err_step;
    logic                w_last;

    // load datapath
    logic signed [W-1:0] l_sx, l_sy, l_ex, l_ey;
    logic signed [W-1:0] l_smaj, l_emaj, l_smin, l_emin;
    logic signed [W-1:0] l_dmaj, l_dmin;
    logic [W-1:0]        l_adm;
    logic [E-1:0]        l_err;

    // handshake: stage 1 moves when empty or when stage 2 takes it
    assign w_en       = !r_s1_valid || i_s2_ready;
    assign w_fire     = i_in_valid && w_en;
    assign o_in_ready = w_en;
    assign w_emit     = (i_operation == OP_STEP) && !r_done;

    // step: error compare, minor move by sign of delta, major move by one
    always_comb begin
        w_major      = r_mode ? r_cur_y : r_cur_x;
        w_minor      = r_mode ? r_cur_x : r_cur_y;
        w_last       = (w_major == {r_target[COORD_BITS-1], r_target});
        w_adm        = r_dmin[W-1] ? W'(-r_dmin) : r_dmin;
        w_adm_e      = {{(E-W){1'b0}}, w_adm};
        w_dmaj_e     = {{(E-W){r_dmaj[W-1]}}, r_dmaj};
        w_err_pos    = !r_err[E-1] && (r_err != '0);
        w_minor_step = w_minor + {{(W-1){r_dmin[W-1]}}, 1'b1};
        w_major_next = w_major + W'(1);
        w_err_step   = w_err_pos ? (r_err + ((w_adm_e - w_dmaj_e) << 1))
                                 : (r_err + (w_adm_e << 1));
    end

    // load: deltas and initial error term
    always_comb begin
        l_sx   = {i_start_x[COORD_BITS-1], i_start_x};
        l_sy   = {i_start_y[COORD_BITS-1], i_start_y};
        l_ex   = {i_end_x[COORD_BITS-1], i_end_x};
        l_ey   = {i_end_y[COORD_BITS-1], i_end_y};
        l_smaj = i_y_major ? l_sy : l_sx;
        l_emaj = i_y_major ? l_ey : l_ex;
        l_smin = i_y_major ? l_sx : l_sy;
        l_emin = i_y_major ? l_ex : l_ey;
        l_dmaj = l_emaj - l_smaj;
        l_dmin = l_emin - l_smin;
        l_adm  = l_dmin[W-1] ? W'(-l_dmin) : l_dmin;
        l_err  = ({{(E-W){1'b0}}, l_adm} << 1) - {{(E-W){l_dmaj[W-1]}}, l_dmaj};
    end

    // next line state
    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_target = r_target;
        n_dmin   = r_dmin;
        n_dmaj   = r_dmaj;
        n_err    = r_err;
        n_mode   = r_mode;
        n_done   = r_done;
        if (w_fire) begin
            if (i_operation == OP_LOAD) begin
                n_cur_x  = l_sx;
                n_cur_y  = l_sy;
                n_target = l_emaj[COORD_BITS-1:0];
                n_dmin   = l_dmin;
                n_dmaj   = l_dmaj;
                n_err    = l_err;
                n_mode   = i_y_major;
                n_done   = (l_smaj > l_emaj);
            end else if (!r_done) begin
                if (r_mode) begin
                    n_cur_y = w_major_next;
                    n_cur_x = w_err_pos ? w_minor_step : r_cur_x;
                end else begin
                    n_cur_x = w_major_next;
                    n_cur_y = w_err_pos ? w_minor_step : r_cur_y;
                end
                n_err = w_err_step;
                if (w_last) begin
                    n_done = 1'b1;
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_target <= '0;
            r_dmin   <= '0;
            r_dmaj   <= '0;
            r_err    <= '0;
            r_mode   <= 1'b0;
            r_done   <= 1'b1;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_target <= n_target;
            r_dmin   <= n_dmin;
            r_dmaj   <= n_dmaj;
            r_err    <= n_err;
            r_mode   <= n_mode;
            r_done   <= n_done;
        end
    end

    // stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // stage 1 payload, zeros when no pixel comes out
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pv   <= w_emit;
            r_px   <= w_emit ? r_cur_x : '0;
            r_py   <= w_emit ? r_cur_y : '0;
            r_last <= w_emit && w_last;
        end
    end

    assign o_s1_valid       = r_s1_valid;
    assign o_s1_pixel_valid = r_pv;
    assign o_s1_x           = r_px;
    assign o_s1_y           = r_py;
    assign o_s1_last        = r_last;

    // last pixel of a line closes it
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_emit && w_last |=> r_done)
        else $error("line still active after its last pixel");

    // a step with no active line leaves the point alone
    a_idle_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (i_operation == OP_STEP) && r_done
        |=> $stable(r_cur_x) && $stable(r_cur_y) && r_done)
        else $error("point moved on a step with no active line");

    // stage 1 payload does not change while it waits
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_s2_ready |=> r_s1_valid && $stable(r_px) && $stable(r_last))
        else $error("stage 1 payload lost while stalled");

endmodule

[src/bls_addr_unit.sv]
// bls_addr_unit: view test, frame-buffer address and output register
// depends on bls_pkg

module bls_addr_unit #(
    parameter int COORD_BITS = 16,
    parameter int ADDR_BITS  = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bls_pkg::t_cfg                i_cfg,
    input  logic                         i_s1_valid,
    output logic                         o_s2_ready,
    input  logic                         i_pixel_valid,
    input  logic signed [COORD_BITS:0]   i_x,
    input  logic signed [COORD_BITS:0]   i_y,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_pixel_valid,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_in_view,
    output logic [ADDR_BITS-1:0]         o_pixel_address,
    output logic                         o_last_pixel
);
    import bls_pkg::*;

    localparam int CW = (COORD_BITS > VIEW_W) ? COORD_BITS : VIEW_W;
    localparam int PW = COORD_BITS + FW_W;
    localparam int SW = (PW + 1 > ADDR_BITS) ? PW + 1 : ADDR_BITS;

    logic                         r_out_valid;
    logic                         r_pixel_valid;
    logic signed [COORD_BITS-1:0] r_pixel_x;
    logic signed [COORD_BITS-1:0] r_pixel_y;
    logic                         r_in_view;
    logic [ADDR_BITS-1:0]         r_addr;
    logic                         r_last;

    logic                 w_x_in;
    logic                 w_y_in;
    logic                 w_view;
    logic [PW-1:0]        w_prod;
    logic [SW-1:0]        w_sum;
    logic [ADDR_BITS-1:0] w_addr;

    assign o_s2_ready = !r_out_valid || i_out_ready;

    // view window test on the full-width point
    assign w_x_in = !i_x[COORD_BITS] &&
                    (CW'(i_x[COORD_BITS-1:0]) < CW'(i_cfg.view_x_limit));
    assign w_y_in = !i_y[COORD_BITS] &&
                    (CW'(i_y[COORD_BITS-1:0]) < CW'(i_cfg.view_y_limit));
    assign w_view = i_pixel_valid && w_x_in && w_y_in;

    // row times width plus column, wrapped to the address width
    assign w_prod = PW'(i_y[COORD_BITS-1:0]) * PW'(i_cfg.frame_width);
    assign w_sum  = SW'(w_prod) + SW'(i_x[COORD_BITS-1:0]);
    assign w_addr = w_view ? w_sum[ADDR_BITS-1:0] : '0;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s2_ready) begin
            r_out_valid <= i_s1_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_s2_ready && i_s1_valid) begin
            r_pixel_valid <= i_pixel_valid;
            r_pixel_x     <= i_x[COORD_BITS-1:0];
            r_pixel_y     <= i_y[COORD_BITS-1:0];
            r_in_view     <= w_view;
            r_addr        <= w_addr;
            r_last        <= i_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_valid   = r_pixel_valid;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_in_view       = r_in_view;
    assign o_pixel_address = r_addr;
    assign o_last_pixel    = r_last;

    // an address only comes with a visible pixel
    a_addr_needs_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_view |-> o_pixel_address == '0)
        else $error("address set outside the view");

    // visibility and last flag only on real pixels
    a_flags_need_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_valid |-> !o_in_view && !o_last_pixel)
        else $error("pixel flags set on an empty result");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench for bresenham_line_stepper: directed and random line traffic with a
// self-checking pixel predictor, random request gaps and result stalls
// depends on bls_pkg and the bresenham_line_stepper rtl

module testbench;

    localparam int CW           = 16;
    localparam int AW           = 26;
    localparam int CFG_DW       = bls_pkg::CFG_DATA_W;
    localparam int DRAIN_PAD    = 6;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [bls_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic                 operation;
        logic                 y_major;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } line_req_t;

    typedef struct packed {
        logic                 pixel_valid;
        logic signed [CW-1:0] pixel_x;
        logic signed [CW-1:0] pixel_y;
        logic                 in_view;
        logic [AW-1:0]        pixel_address;
        logic                 last_pixel;
    } pixel_t;

    // dut ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [bls_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [bls_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_operation = 1'b0;
    logic                            i_y_major = 1'b0;
    logic signed [CW-1:0]            i_start_x = '0;
    logic signed [CW-1:0]            i_start_y = '0;
    logic signed [CW-1:0]            i_end_x = '0;
    logic signed [CW-1:0]            i_end_y = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic                            o_pixel_valid;
    logic signed [CW-1:0]            o_pixel_x;
    logic signed [CW-1:0]            o_pixel_y;
    logic                            o_in_view;
    logic [AW-1:0]                   o_pixel_address;
    logic                            o_last_pixel;

    // request queue, expected pixels and bookkeeping
    line_req_t item_q[$];
    pixel_t    pixel_q[$];
    int        errors = 0;
    int        cycle_count = 0;
    logic      in_taken = 1'b0;
    int        send_burst = 0;
    int        send_gap = 0;
    int        ready_run = 0;
    int        stall_run = 0;

    // mirrored view and frame registers
    int view_w_lim = int'(bls_pkg::VIEW_X_RESET);
    int view_h_lim = int'(bls_pkg::VIEW_Y_RESET);
    int row_pitch  = int'(bls_pkg::FW_RESET);

    // mirrored line state
    logic signed [CW:0]   cur_x = '0;
    logic signed [CW:0]   cur_y = '0;
    logic signed [CW-1:0] major_end = '0;
    logic signed [CW:0]   dminor = '0;
    logic signed [CW:0]   dmajor = '0;
    logic signed [CW+3:0] err_acc = '0;
    logic                 by_y = 1'b0;
    logic                 line_idle = 1'b1;

    bresenham_line_stepper #(
        .COORD_BITS (CW),
        .ADDR_BITS  (AW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_y_major       (i_y_major),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_in_view       (o_in_view),
        .o_pixel_address (o_pixel_address),
        .o_last_pixel    (o_last_pixel)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // pixel predictor: applies one request to the mirrored line state
    function automatic pixel_t rasterize(input line_req_t req);
        pixel_t px;
        longint dmin, dmaj, adm, cx, cy;
        logic   view, last;
        px = '0;
        if (req.operation == bls_pkg::OP_LOAD) begin
            by_y  = req.y_major;
            cur_x = {req.start_x[CW-1], req.start_x};
            cur_y = {req.start_y[CW-1], req.start_y};
            if (by_y) begin
                major_end = req.end_y;
                dminor    = {req.end_x[CW-1], req.end_x} - {req.start_x[CW-1], req.start_x};
                dmajor    = {req.end_y[CW-1], req.end_y} - {req.start_y[CW-1], req.start_y};
                line_idle = $signed(req.start_y) > $signed(req.end_y);
            end else begin
                major_end = req.end_x;
                dminor    = {req.end_y[CW-1], req.end_y} - {req.start_y[CW-1], req.start_y};
                dmajor    = {req.end_x[CW-1], req.end_x} - {req.start_x[CW-1], req.start_x};
                line_idle = $signed(req.start_x) > $signed(req.end_x);
            end
            dmin    = longint'(dminor);
            dmaj    = longint'(dmajor);
            adm     = (dmin < 0) ? -dmin : dmin;
            err_acc = (CW+4)'(2 * adm - dmaj);
        end else if (!line_idle) begin
            cx   = longint'(cur_x);
            cy   = longint'(cur_y);
            dmin = longint'(dminor);
            dmaj = longint'(dmajor);
            adm  = (dmin < 0) ? -dmin : dmin;
            view = (cx >= 0) && (cx < longint'(view_w_lim)) &&
                   (cy >= 0) && (cy < longint'(view_h_lim));
            last = by_y ? (cy == longint'(major_end)) : (cx == longint'(major_end));
            px.pixel_valid = 1'b1;
            px.pixel_x     = cur_x[CW-1:0];
            px.pixel_y     = cur_y[CW-1:0];
            px.in_view     = view;
            if (view)
                px.pixel_address = AW'(cy * longint'(row_pitch) + cx);
            px.last_pixel  = last;
            // minor axis moves only on a positive error term
            if (err_acc > 0) begin
                if (by_y)
                    cur_x = (CW+1)'(cur_x + ((dmin < 0) ? -1 : 1));
                else
                    cur_y = (CW+1)'(cur_y + ((dmin < 0) ? -1 : 1));
                err_acc = (CW+4)'(longint'(err_acc) + 2 * (adm - dmaj));
            end else begin
                err_acc = (CW+4)'(longint'(err_acc) + 2 * adm);
            end
            if (by_y)
                cur_y = (CW+1)'(cur_y + 1);
            else
                cur_x = (CW+1)'(cur_x + 1);
            if (last)
                line_idle = 1'b1;
        end
        return px;
    endfunction

    // accepted requests feed the predictor, accepted writes the register mirror
    always @(posedge i_clk) begin : track_requests
        line_req_t req;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                req.operation = i_operation;
                req.y_major   = i_y_major;
                req.start_x   = i_start_x;
                req.start_y   = i_start_y;
                req.end_x     = i_end_x;
                req.end_y     = i_end_y;
                pixel_q.push_back(rasterize(req));
                in_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bls_pkg::REG_VIEW_X_LIMIT: view_w_lim = int'(i_cfg_data[bls_pkg::VIEW_W-1:0]);
                    bls_pkg::REG_VIEW_Y_LIMIT: view_h_lim = int'(i_cfg_data[bls_pkg::VIEW_W-1:0]);
                    bls_pkg::REG_FRAME_WIDTH:  row_pitch  = int'(i_cfg_data[bls_pkg::FW_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // request driver: bursts of random length with random gaps
    always @(negedge i_clk) begin : drive_requests
        line_req_t nxt;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (item_q.size() != 0) begin
                nxt = item_q.pop_front();
                i_operation <= nxt.operation;
                i_y_major   <= nxt.y_major;
                i_start_x   <= nxt.start_x;
                i_start_y   <= nxt.start_y;
                i_end_x     <= nxt.end_x;
                i_end_y     <= nxt.end_y;
                i_in_valid  <= 1'b1;
                if (send_burst > 0) begin
                    send_burst--;
                end else begin
                    send_burst = $urandom_range(0, 40);
                    send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall pattern: ready runs broken by stalls, some runs unbroken
    always @(negedge i_clk) begin : drive_out_ready
        logic rdy;
        if (ready_run > 0) begin
            ready_run--;
            rdy = 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            rdy = 1'b0;
        end else begin
            ready_run = $urandom_range(0, 40);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            rdy       = 1'b1;
        end
        i_out_ready <= rdy;
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // result monitor: each accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_pixels
        pixel_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
            end else begin
                want = pixel_q.pop_front();
                compare_field("pixel_valid", 32'(want.pixel_valid), 32'(o_pixel_valid));
                compare_field("pixel_x", 32'(unsigned'(want.pixel_x)), 32'(unsigned'(o_pixel_x)));
                compare_field("pixel_y", 32'(unsigned'(want.pixel_y)), 32'(unsigned'(o_pixel_y)));
                compare_field("in_view", 32'(want.in_view), 32'(o_in_view));
                compare_field("pixel_address", 32'(want.pixel_address), 32'(o_pixel_address));
                compare_field("last_pixel", 32'(want.last_pixel), 32'(o_last_pixel));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_load(input logic ymaj, input int sx, input int sy,
                             input int ex, input int ey);
        line_req_t req;
        req.operation = bls_pkg::OP_LOAD;
        req.y_major   = ymaj;
        req.start_x   = CW'(sx);
        req.start_y   = CW'(sy);
        req.end_x     = CW'(ex);
        req.end_y     = CW'(ey);
        item_q.push_back(req);
    endtask

    // step requests carry random don't-care fields
    task automatic push_steps(input int n);
        line_req_t req;
        for (int k = 0; k < n; k++) begin
            req.operation = bls_pkg::OP_STEP;
            req.y_major   = 1'($urandom_range(0, 1));
            req.start_x   = CW'($urandom);
            req.start_y   = CW'($urandom);
            req.end_x     = CW'($urandom);
            req.end_y     = CW'($urandom);
            item_q.push_back(req);
        end
    endtask

    // start coordinate such that start and start + span both fit
    function automatic int pick_start(input int span);
        int lo, hi, near_lo, near_hi, style;
        lo      = (span < 0) ? -32768 - span : -32768;
        hi      = (span > 0) ? 32767 - span : 32767;
        near_lo = (lo > -4) ? lo : -4;
        near_hi = ($urandom_range(0, 1) == 0) ? 80 : 2000;
        near_hi = (hi < near_hi) ? hi : near_hi;
        style   = $urandom_range(0, 5);
        if (style <= 2 && near_lo <= near_hi)
            return near_lo + int'($urandom_range(0, near_hi - near_lo));
        else if (style == 3)
            return ($urandom_range(0, 1) == 0) ? lo : hi;
        else
            return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // mostly whole lines with random geometry, some cut short, some noise
    task automatic queue_line_traffic(input int n_items);
        line_req_t req;
        int        pushed, kind, span, mspan, n_steps, smaj, smin;
        logic      ymaj;
        pushed = 0;
        while (pushed < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                req = {2'($urandom), $urandom, $urandom};
                item_q.push_back(req);
                pushed++;
            end else begin
                ymaj = 1'($urandom_range(0, 1));
                if (kind == 1)
                    span = 0 - int'($urandom_range(1, 300));
                else if (kind == 2)
                    span = $urandom_range(13, 150);
                else
                    span = $urandom_range(0, 12);
                // steep line in the wrong mode
                if (kind == 3)
                    mspan = $urandom_range(span + 1, 65535);
                else
                    mspan = $urandom_range(0, (span < 0) ? 300 : span);
                if ($urandom_range(0, 1) == 0)
                    mspan = -mspan;
                smaj = pick_start(span);
                smin = pick_start(mspan);
                if (ymaj)
                    push_load(ymaj, smin, smaj, smin + mspan, smaj + span);
                else
                    push_load(ymaj, smaj, smin, smaj + span, smin + mspan);
                if (span < 0)
                    n_steps = $urandom_range(1, 2);
                else if ($urandom_range(0, 6) == 0)
                    n_steps = $urandom_range(0, span);
                else
                    n_steps = span + 1 + int'($urandom_range(0, 2));
                push_steps(n_steps);
                pushed += 1 + n_steps;
            end
        end
    endtask

    // hold the sender until every expected pixel has come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (item_q.size() != 0 || i_in_valid || pixel_q.size() != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bls_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bls_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    task automatic program_regs(input int xlim, input int ylim, input int fw,
                                input logic poke_spare);
        write_reg(bls_pkg::REG_VIEW_X_LIMIT, CFG_DW'(xlim));
        write_reg(bls_pkg::REG_VIEW_Y_LIMIT, CFG_DW'(ylim));
        write_reg(bls_pkg::REG_FRAME_WIDTH, CFG_DW'(fw));
        if (poke_spare)
            write_reg(CFG_IDX_SPARE, CFG_DW'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : run_sequence
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines under reset registers
        push_steps(1);
        push_load(1'b0, 0, -32768, 10, 32767);
        push_steps(12);
        push_load(1'b1, -32768, -32768, 32767, 32767);
        push_steps(2);
        push_load(1'b0, 32767, 5, -32768, 5);
        push_steps(1);
        push_load(1'b1, 7, 9, 7, 9);
        push_steps(2);
        queue_line_traffic(120);
        wait_drained();

        // widest view, frame width 8192: large addresses wrap
        program_regs(32767, 32767, 8192, 1'b1);
        queue_line_traffic(150);
        wait_drained();

        // empty view
        program_regs(0, 0, 1, 1'b0);
        queue_line_traffic(80);
        wait_drained();

        // small view, frame width field written as zero
        program_regs(64, 48, 15'h4000, 1'b1);
        queue_line_traffic(150);
        wait_drained();

        program_regs($urandom_range(1, 4000), $urandom_range(1, 4000),
                     $urandom_range(1, 8192), 1'b0);
        queue_line_traffic(200);
        wait_drained();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
src/bls_pkg.sv
src/bls_cfg_regs.sv
src/bls_stepper.sv
src/bls_addr_unit.sv
src/bresenham_line_stepper.sv
verif/testbench.sv
